/* sv/shifting_list_insert_delete_core_assert.svh */
// ----------------------------------------------------------------------------
// shifting_list_insert_delete_core_assert
// Assertion macros shared by the list core.
// ----------------------------------------------------------------------------
`ifndef SHIFTING_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define SHIFTING_LIST_INSERT_DELETE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLID_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list core assertion failed");

// Next-cycle implication, disabled during reset.
`define SLID_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list core assertion failed");

`endif

/* sv/slid_pkg.sv */
// ----------------------------------------------------------------------------
// slid_pkg
// Types and constants shared by the shifting list core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package slid_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = 7;    // count field, holds 0..LIST_DEPTH
  localparam int DATA_W     = 32;
  localparam int GROUP      = 8;    // cells per scan group
  localparam int NGROUPS    = (LIST_DEPTH + GROUP - 1) / GROUP;

  localparam logic [2:0] CMD_INS_END   = 3'd0;
  localparam logic [2:0] CMD_INS_FRONT = 3'd1;
  localparam logic [2:0] CMD_INS_POS   = 3'd2;
  localparam logic [2:0] CMD_DEL_FIRST = 3'd3;
  localparam logic [2:0] CMD_DEL_LAST  = 3'd4;
  localparam logic [2:0] CMD_DEL_VAL   = 3'd5;
  localparam logic [2:0] CMD_READ      = 3'd6;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_BAD_POS   = 3'd1;
  localparam logic [2:0] STATUS_FULL      = 3'd2;
  localparam logic [2:0] STATUS_EMPTY     = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t            op;
    logic                use_found;  // delete point comes from the scan
    logic [CNT_W-1:0]    pivot;
    logic [DATA_W-1:0]   value;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    rd_pos;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/slid_cell.sv */
// ----------------------------------------------------------------------------
// slid_cell
// One list entry: compares against the broadcast value, offers its entry for
// a read and takes its left or right neighbor on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module slid_cell (
  input  logic                       clk,
  input  slid_pkg::cell_ctl_t        ctl,
  input  logic [slid_pkg::IDX_W-1:0] idx,
  input  logic [slid_pkg::DATA_W-1:0] left_data,
  input  logic [slid_pkg::DATA_W-1:0] right_data,
  input  logic                       found_ge,
  output logic [slid_pkg::DATA_W-1:0] data,
  output logic                       match,
  output logic [slid_pkg::DATA_W-1:0] rd_part
);
  import slid_pkg::*;

  logic [CNT_W-1:0] idx_ext;
  logic             at_or_after;
  logic             after;
  logic             at;

  assign idx_ext     = CNT_W'(idx);
  assign at          = (idx_ext == ctl.pivot);
  assign after       = (idx_ext > ctl.pivot);
  assign at_or_after = ctl.use_found ? found_ge : (idx_ext >= ctl.pivot);

  always_ff @(posedge clk) begin
    match   <= (data == ctl.value) && (idx_ext < ctl.count);
    rd_part <= (idx_ext == ctl.rd_pos) ? data : '0;
    unique case (ctl.op)
      CELL_HOLD: ;
      CELL_INSERT: begin
        if (after) begin
          data <= left_data;
        end else if (at) begin
          data <= ctl.value;
        end
      end
      CELL_DELETE: begin
        if (at_or_after) begin
          data <= right_data;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/slid_scan.sv */
// ----------------------------------------------------------------------------
// slid_scan
// Registered two-level tree over the cell row: first-match position for
// delete by value and the OR of the read parts.
// ----------------------------------------------------------------------------
`default_nettype none

module slid_scan (
  input  logic                        clk,
  input  logic [slid_pkg::LIST_DEPTH-1:0] match,
  input  logic [slid_pkg::DATA_W-1:0] rd_part [slid_pkg::LIST_DEPTH],
  output logic [slid_pkg::LIST_DEPTH-1:0] found_ge,
  output logic                        found,
  output logic [slid_pkg::DATA_W-1:0] rd_value
);
  import slid_pkg::*;

  logic [LIST_DEPTH-1:0] pre;       // a match lower in the same group
  logic [LIST_DEPTH-1:0] pre_r;
  logic [LIST_DEPTH-1:0] match_r;
  logic [NGROUPS-1:0]    grp_any;
  logic [NGROUPS-1:0]    grp_any_r;
  logic [NGROUPS-1:0]    grp_before;
  logic [DATA_W-1:0]     grp_rd   [NGROUPS];
  logic [DATA_W-1:0]     grp_rd_r [NGROUPS];

  for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
    localparam int BASE = g * GROUP;
    localparam int GL   = (LIST_DEPTH - BASE < GROUP) ? (LIST_DEPTH - BASE) : GROUP;

    for (genvar k = 0; k < GL; k++) begin : g_bit
      if (k == 0) begin : g_first
        assign pre[BASE] = 1'b0;
      end else begin : g_rest
        assign pre[BASE+k] = |match[BASE+k-1 -: k];
      end
      assign found_ge[BASE+k] = match_r[BASE+k] | pre_r[BASE+k] | grp_before[g];
    end

    assign grp_any[g] = |match[BASE +: GL];

    always_comb begin
      grp_rd[g] = '0;
      for (int k = 0; k < GL; k++) begin
        grp_rd[g] = grp_rd[g] | rd_part[BASE+k];
      end
    end

    if (g == 0) begin : g_b0
      assign grp_before[g] = 1'b0;
    end else begin : g_bn
      assign grp_before[g] = |grp_any_r[g-1:0];
    end
  end

  always_ff @(posedge clk) begin
    match_r   <= match;
    pre_r     <= pre;
    grp_any_r <= grp_any;
    grp_rd_r  <= grp_rd;
  end

  assign found = |grp_any_r;

  always_comb begin
    rd_value = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      rd_value = rd_value | grp_rd_r[g];
    end
  end

endmodule

`default_nettype wire

/* sv/shifting_list_insert_delete_core.sv */
// ----------------------------------------------------------------------------
// shifting_list_insert_delete_core
// Ordered list of 32-bit entries held in a row of cells, with a count.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream, one transfer per command; each command
//   gives exactly one result transfer on the m_ stream (status, count after
//   the command, read value).
//   After its transfer a command runs through the compare, scan and apply states:
//   the cells compare and offer their entries, a registered group tree finds the
//   first match and the read data, and the apply state updates all cells at once
//   (shift left, shift right or hold) and loads the result register.
//   A new command is taken only once the previous one has passed its update,
//   since the compare / scan / update sequence shares the single row of cells.
//   s_tready is high only between commands. If the receiver stalls with a
//   result still waiting, the next command is still taken and runs up to its
//   update cycle, where it holds until the result register is free.
//   Reset clears the count, the sequencer and the output valid; entry
//   contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shifting_list_insert_delete_core_assert.svh"

module shifting_list_insert_delete_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // command[2:0], value[34:3], position[41:35], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status[2:0], new_count[9:3], read_value[41:10], zero pad
);
  import slid_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [2:0]        cmd_r;
  logic [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]  pos_r;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [2:0]        status;
  logic [2:0]        status_next;
  logic [CNT_W-1:0]  out_count;
  logic [DATA_W-1:0] read_value;
  logic [DATA_W-1:0] rd_next;
  logic              out_free;
  logic              apply_go;
  cell_ctl_t         ctl;

  logic [DATA_W-1:0]     cell_data [LIST_DEPTH];
  logic [DATA_W-1:0]     rd_part   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match;
  logic [LIST_DEPTH-1:0] found_ge;
  logic                  found;
  logic [DATA_W-1:0]     scan_rd;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_l0
      assign left_d = ctl.value;
    end else begin : g_ln
      assign left_d = cell_data[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_rl
      assign right_d = '0;
    end else begin : g_rn
      assign right_d = cell_data[i+1];
    end
    slid_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .found_ge   (found_ge[i]),
      .data       (cell_data[i]),
      .match      (match[i]),
      .rd_part    (rd_part[i])
    );
  end

  slid_scan u_scan (
    .clk      (clk),
    .match    (match),
    .rd_part  (rd_part),
    .found_ge (found_ge),
    .found    (found),
    .rd_value (scan_rd)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {6'b0, read_value, out_count, status};

  always_comb begin
    state_next    = state;
    apply_go      = 1'b0;
    count_next    = count;
    status_next   = STATUS_OK;
    rd_next       = '0;
    ctl.op        = CELL_HOLD;
    ctl.use_found = 1'b0;
    ctl.pivot     = '0;
    ctl.value     = value_r;
    ctl.count     = count;
    ctl.rd_pos    = pos_r;

    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CMP;
      ST_CMP:   state_next = ST_SCAN;
      ST_SCAN:  state_next = ST_APPLY;
      ST_APPLY: begin
        if (out_free) begin
          apply_go   = 1'b1;
          state_next = ST_IDLE;
          unique case (cmd_r)
            CMD_INS_END, CMD_INS_FRONT, CMD_INS_POS: begin
              if (cmd_r == CMD_INS_END) begin
                ctl.pivot = count;
              end else if (cmd_r == CMD_INS_POS) begin
                ctl.pivot = pos_r;
              end
              if (cmd_r == CMD_INS_POS && pos_r > count) begin
                status_next = STATUS_BAD_POS;
              end else if (count >= CNT_W'(LIST_DEPTH)) begin
                status_next = STATUS_FULL;
              end else begin
                ctl.op     = CELL_INSERT;
                count_next = count + 1'b1;
              end
            end
            CMD_DEL_FIRST: begin
              if (count == '0) begin
                status_next = STATUS_EMPTY;
              end else begin
                ctl.op     = CELL_DELETE;
                count_next = count - 1'b1;
              end
            end
            CMD_DEL_LAST: begin
              if (count == '0) begin
                status_next = STATUS_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            CMD_DEL_VAL: begin
              if (count == '0) begin
                status_next = STATUS_EMPTY;
              end else if (!found) begin
                status_next = STATUS_NOT_FOUND;
              end else begin
                ctl.op        = CELL_DELETE;
                ctl.use_found = 1'b1;
                count_next    = count - 1'b1;
              end
            end
            CMD_READ: begin
              if (pos_r >= count) begin
                status_next = STATUS_BAD_POS;
              end else begin
                rd_next = scan_rd;
              end
            end
            default: ;  // unused code: no change
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (apply_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_r   <= s_tdata[2:0];
      value_r <= s_tdata[34:3];
      pos_r   <= s_tdata[41:35];
    end
    if (apply_go) begin
      status     <= status_next;
      out_count  <= count_next;
      read_value <= rd_next;
    end
  end

  `SLID_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CNT_W'(LIST_DEPTH))
  `SLID_ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, state == ST_CMP)
  `SLID_ASSERT_NEXT(a_count_only_on_apply, clk, rst, state != ST_APPLY, $stable(count))
  `SLID_ASSERT_NEXT(a_apply_gives_result, clk, rst, state == ST_APPLY && out_free,
                    m_tvalid && state == ST_IDLE)

endmodule

`default_nettype wire

/* bench/shifting_list_insert_delete_core_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shifting_list_insert_delete_core_checker
// Scoreboard for the list core. It keeps its own copy of the list, works out
// the result of every command transfer and compares each result transfer
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------

module shifting_list_insert_delete_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // command[2:0], value[34:3], position[41:35], zero pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // status[2:0], new_count[9:3], read_value[41:10], zero pad
  output int          fail_count,
  output int          pending_results,
  output int          list_count
);

  import slid_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [2:0]        status;
    logic [CNT_W-1:0]  new_count;
    logic [DATA_W-1:0] read_value;
  } list_result_t;

  logic [DATA_W-1:0] entries [LIST_DEPTH];
  int                n_entries;
  int                result_index;
  list_result_t      expected_results [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    list_count      = 0;
    n_entries       = 0;
    result_index    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("%0t: result %0d: %s is %0h, expected %0h",
               $time, result_index, what, got, want);
  endtask

  // Apply one command to the list copy and return the result it gives.
  task automatic run_command(input logic [2:0] cmd, input logic [DATA_W-1:0] value,
                             input logic [6:0] pos, output list_result_t res);
    int at;
    int hit;
    res        = '0;
    res.status = STATUS_OK;
    case (cmd)
      CMD_INS_END, CMD_INS_FRONT, CMD_INS_POS: begin
        if (cmd == CMD_INS_END)
          at = n_entries;
        else if (cmd == CMD_INS_FRONT)
          at = 0;
        else
          at = int'(pos);
        // position check wins over the full check
        if (at > n_entries)
          res.status = STATUS_BAD_POS;
        else if (n_entries >= LIST_DEPTH)
          res.status = STATUS_FULL;
        else begin
          for (int i = n_entries; i > at; i--)
            entries[i] = entries[i-1];
          entries[at] = value;
          n_entries++;
        end
      end
      CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_VAL: begin
        if (n_entries == 0)
          res.status = STATUS_EMPTY;
        else if (cmd == CMD_DEL_LAST)
          n_entries--;
        else begin
          hit = -1;
          if (cmd == CMD_DEL_FIRST)
            hit = 0;
          else
            for (int i = 0; i < n_entries; i++)
              if (hit < 0 && entries[i] == value)
                hit = i;
          if (hit < 0)
            res.status = STATUS_NOT_FOUND;
          else begin
            for (int i = hit; i + 1 < n_entries; i++)
              entries[i] = entries[i+1];
            n_entries--;
          end
        end
      end
      CMD_READ: begin
        if (int'(pos) >= n_entries)
          res.status = STATUS_BAD_POS;
        else
          res.read_value = entries[pos];
      end
      default: ;  // unused code: no change
    endcase
    res.new_count = CNT_W'(n_entries);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      n_entries = 0;
      expected_results.delete();
    end else begin
      // results first: a result never belongs to a command taken at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0)
          report_mismatch("result with nothing expected", m_tdata[31:0], '0);
        else begin
          want = expected_results.pop_front();
          if (m_tdata[2:0] !== want.status)
            report_mismatch("status", m_tdata[2:0], want.status);
          if (m_tdata[9:3] !== want.new_count)
            report_mismatch("new_count", m_tdata[9:3], want.new_count);
          if (m_tdata[41:10] !== want.read_value)
            report_mismatch("read_value", m_tdata[41:10], want.read_value);
        end
        result_index++;
      end
      if (s_tvalid && s_tready) begin
        run_command(s_tdata[2:0], s_tdata[34:3], s_tdata[41:35], want);
        expected_results.push_back(want);
      end
    end
    pending_results <= expected_results.size();
    list_count      <= n_entries;
  end

endmodule

/* bench/shifting_list_insert_delete_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shifting_list_insert_delete_core_test
// Stimulus and verdict for the list core: a directed pass over the empty,
// bad position, not found and edge value cases, then random command runs
// that swing the list between empty and full under varying backpressure.
// ----------------------------------------------------------------------------

module shifting_list_insert_delete_core_test;

  import slid_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 1850;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 24;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [47:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;

  int send_idle_pct    = 28;
  int recv_idle_pct    = 49;
  int long_holds_asked = 0;
  int long_holds_done  = 0;
  int hold_left        = 0;
  int quiet_cycles     = 0;
  int fail_count;
  int pending_results;
  int list_count;

  always #5 clk = ~clk;

  shifting_list_insert_delete_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  shifting_list_insert_delete_core_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .list_count      (list_count)
  );

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left == 0 && long_holds_done < long_holds_asked) begin
      hold_left = LONG_HOLD;
      long_holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[shifting_list_insert_delete_core] ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] value,
                          input logic [6:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, pos, value, cmd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Pooled values repeat often, so delete by value finds its target.
  function automatic logic [31:0] pick_value(input bit pooled);
    if (!pooled && $urandom_range(1) == 0)
      return $urandom();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return 32'($urandom_range(7));
    endcase
  endfunction

  task automatic random_cmd(input int insert_pct);
    int          r;
    logic [2:0]  cmd;
    logic [6:0]  pos;
    logic [31:0] value;
    r = $urandom_range(99);
    if (r == 0)
      cmd = CMD_UNUSED;
    else if (r <= insert_pct)
      case ($urandom_range(2))
        0:       cmd = CMD_INS_END;
        1:       cmd = CMD_INS_FRONT;
        default: cmd = CMD_INS_POS;
      endcase
    else if (r <= insert_pct + 15)
      cmd = CMD_READ;
    else
      case ($urandom_range(2))
        0:       cmd = CMD_DEL_FIRST;
        1:       cmd = CMD_DEL_LAST;
        default: cmd = CMD_DEL_VAL;
      endcase
    value = pick_value(cmd == CMD_DEL_VAL && $urandom_range(3) != 0);
    if ($urandom_range(6) == 0)
      pos = 7'($urandom_range(LIST_DEPTH));
    else if (cmd == CMD_READ && list_count > 0)
      pos = 7'($urandom_range(list_count - 1));
    else
      pos = 7'($urandom_range(list_count));
    send_cmd(cmd, value, pos);
  endtask

  // Runs of filling, draining or mixed traffic so the list hits both ends.
  task automatic random_phase(input int n_items);
    int left;
    int seg;
    int insert_pct;
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(150, 20);
      if (seg > left)
        seg = left;
      case ($urandom_range(2))
        0:       insert_pct = 80;
        1:       insert_pct = 20;
        default: insert_pct = 45;
      endcase
      repeat (seg) random_cmd(insert_pct);
      left -= seg;
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list
    send_cmd(CMD_DEL_FIRST, 32'h0, 7'd0);
    send_cmd(CMD_DEL_LAST,  32'h0, 7'd0);
    send_cmd(CMD_DEL_VAL,   32'h0, 7'd0);
    send_cmd(CMD_READ,      32'h0, 7'd0);
    send_cmd(CMD_INS_POS,   32'h1, 7'd1);
    send_cmd(CMD_UNUSED,    32'hFFFF_FFFF, 7'd64);
    // build [min, 0, max, -1]
    send_cmd(CMD_INS_END,   32'h7FFF_FFFF, 7'd0);
    send_cmd(CMD_INS_FRONT, 32'h8000_0000, 7'd0);
    send_cmd(CMD_INS_POS,   32'hFFFF_FFFF, 7'd2);
    send_cmd(CMD_INS_POS,   32'h0000_0000, 7'd1);
    send_cmd(CMD_READ,      32'h0, 7'd0);
    send_cmd(CMD_READ,      32'h0, 7'd3);
    send_cmd(CMD_READ,      32'h0, 7'd4);
    send_cmd(CMD_READ,      32'h0, 7'd64);
    send_cmd(CMD_DEL_VAL,   32'h0001_2345, 7'd0);
    // duplicates: only the first equal entry goes
    send_cmd(CMD_INS_END,   32'h5, 7'd0);
    send_cmd(CMD_INS_END,   32'h5, 7'd0);
    send_cmd(CMD_INS_POS,   32'h5, 7'd0);
    send_cmd(CMD_DEL_VAL,   32'h5, 7'd0);
    send_cmd(CMD_READ,      32'h0, 7'd4);
    send_cmd(CMD_DEL_FIRST, 32'h0, 7'd0);
    send_cmd(CMD_DEL_LAST,  32'h0, 7'd0);
    send_cmd(CMD_INS_POS,   32'h9, 7'd64);
    send_cmd(CMD_DEL_VAL,   32'hFFFF_FFFF, 7'd0);

    long_holds_asked++;
    random_phase(RANDOM_ITEMS / 3);
    send_idle_pct = 49;
    recv_idle_pct = 28;
    random_phase(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_holds_asked++;
    random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    s_tvalid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("[shifting_list_insert_delete_core] OK");
    else
      $display("[shifting_list_insert_delete_core] ERROR");
    $finish;
  end

endmodule
